[sv/vcp_capability_list_parser_macros.svh]
// assertion macros for the vcp capability list parser
`ifndef VCP_CAPABILITY_LIST_PARSER_MACROS_SVH
`define VCP_CAPABILITY_LIST_PARSER_MACROS_SVH

// same-cycle implication, checked outside reset
`define VCP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define VCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/vcp_pkg.sv]
// shared types, codes and helpers of the vcp capability list parser
`default_nettype none

package vcp_pkg;

  localparam int unsigned MAX_NEST_DEPTH_DEF = 255;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned CHAR_W = 16;
  localparam int unsigned BYTE_W = 8;

  typedef enum logic [1:0] {
    KIND_CODE  = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_DONE  = 2'd2
  } vcp_kind_t;

  // one queue entry: results caused by one character
  typedef struct packed {
    logic              has_item;
    logic              item_is_value;
    logic [BYTE_W-1:0] byte_val;
    logic              has_done;
    logic              found;
  } vcp_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } vcp_qstat_t;

  // hex digit decode: bit 4 set when the character is a hex digit
  function automatic logic [4:0] hex_nibble(input logic [CHAR_W-1:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 16'h0030 && c <= 16'h0039) begin
      r = {1'b1, 4'(c - 16'h0030)};
    end else if (c >= 16'h0061 && c <= 16'h0066) begin
      r = {1'b1, 4'(c - 16'h0057)};
    end else if (c >= 16'h0041 && c <= 16'h0046) begin
      r = {1'b1, 4'(c - 16'h0037)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/vcp_front.sv]
// front end: keyword search, depth tracking and list decode, one character per cycle while accept is high
`default_nettype none

module vcp_front #(
  parameter int unsigned MAX_NEST_DEPTH = vcp_pkg::MAX_NEST_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         accept,
  input  wire logic [vcp_pkg::CHAR_W-1:0]   char_code,
  input  wire logic                         end_of_string,
  output logic                              push_valid,
  output vcp_pkg::vcp_entry_t               push_entry
);

  localparam int unsigned DW = $clog2(MAX_NEST_DEPTH + 1);
  localparam logic [DW-1:0] DEPTH_MAX = DW'(MAX_NEST_DEPTH);
  localparam logic [DW-1:0] DEPTH_ONE = DW'(1);

  localparam logic [15:0] CH_NUL   = 16'h0000;
  localparam logic [15:0] CH_TAB   = 16'h0009;
  localparam logic [15:0] CH_SPACE = 16'h0020;
  localparam logic [15:0] CH_OPEN  = 16'h0028;
  localparam logic [15:0] CH_CLOSE = 16'h0029;
  localparam logic [15:0] CH_UC_V  = 16'h0056;
  localparam logic [15:0] CH_LC_V  = 16'h0076;
  localparam logic [15:0] CH_UC_C  = 16'h0043;
  localparam logic [15:0] CH_LC_C  = 16'h0063;
  localparam logic [15:0] CH_UC_P  = 16'h0050;
  localparam logic [15:0] CH_LC_P  = 16'h0070;

  typedef enum logic [2:0] {
    S_SEEK   = 3'd0,
    S_GOT_V  = 3'd1,
    S_GOT_VC = 3'd2,
    S_GOT_KW = 3'd3,
    S_LIST   = 3'd4,
    S_CLOSED = 3'd5
  } search_t;

  typedef enum logic [2:0] {
    B_CODE_HI = 3'd0,
    B_CODE_LO = 3'd1,
    B_AFTER   = 3'd2,
    B_VALUES  = 3'd3,
    B_SKIP    = 3'd4,
    B_STOP    = 3'd5
  } body_t;

  search_t       search_r, search_nxt;
  body_t         body_r, body_nxt;
  logic [DW-1:0] outer_r, outer_nxt;
  logic [DW-1:0] skip_r, skip_nxt;
  logic [3:0]    nib_r, nib_nxt;
  logic          nib_v_r, nib_v_nxt;
  logic          finished_r, finished_nxt;

  logic       is_open, is_close, is_space, is_tab, is_v, is_c, is_p, is_nul;
  logic [4:0] hex;
  logic       body_en, take_rest, eos;
  vcp_pkg::vcp_entry_t ent;

  assign is_nul   = (char_code == CH_NUL);
  assign is_open  = (char_code == CH_OPEN);
  assign is_close = (char_code == CH_CLOSE);
  assign is_space = (char_code == CH_SPACE);
  assign is_tab   = (char_code == CH_TAB);
  assign is_v     = (char_code == CH_UC_V) || (char_code == CH_LC_V);
  assign is_c     = (char_code == CH_UC_C) || (char_code == CH_LC_C);
  assign is_p     = (char_code == CH_UC_P) || (char_code == CH_LC_P);
  assign hex      = vcp_pkg::hex_nibble(char_code);

  always_comb begin
    search_nxt   = search_r;
    body_nxt     = body_r;
    outer_nxt    = outer_r;
    skip_nxt     = skip_r;
    nib_nxt      = nib_r;
    nib_v_nxt    = nib_v_r;
    finished_nxt = finished_r;
    body_en      = 1'b0;
    take_rest    = 1'b0;
    eos          = end_of_string || is_nul;
    ent          = '0;

    if (!finished_r) begin
      // keyword search and outer depth
      if (!is_nul) begin
        case (search_r)
          S_SEEK, S_GOT_V, S_GOT_VC, S_GOT_KW: begin
            if (search_r == S_GOT_V && is_c) begin
              search_nxt = S_GOT_VC;
            end else if (search_r == S_GOT_VC && is_p) begin
              search_nxt = S_GOT_KW;
            end else if (search_r == S_GOT_KW && (is_space || is_tab)) begin
              search_nxt = S_GOT_KW;
            end else if (search_r == S_GOT_KW && is_open) begin
              search_nxt = S_LIST;
              outer_nxt  = DEPTH_ONE;
            end else if (is_v) begin
              search_nxt = S_GOT_V;
            end else begin
              search_nxt = S_SEEK;
            end
          end
          S_LIST: begin
            if (is_open) begin
              if (outer_r < DEPTH_MAX) outer_nxt = outer_r + DEPTH_ONE;
              body_en = 1'b1;
            end else if (is_close) begin
              outer_nxt = outer_r - DEPTH_ONE;
              if (outer_r == DEPTH_ONE) search_nxt = S_CLOSED;
              else body_en = 1'b1;
            end else if (!is_space) begin
              body_en = 1'b1;
            end
          end
          default: ;
        endcase
      end

      // list body decode
      if (body_en) begin
        case (body_r)
          B_AFTER, B_CODE_HI: begin
            if (body_r == B_AFTER && is_open) begin
              body_nxt  = B_VALUES;
              nib_v_nxt = 1'b0;
            end else if (!hex[4]) begin
              body_nxt = B_STOP;
            end else begin
              nib_nxt  = hex[3:0];
              body_nxt = B_CODE_LO;
            end
          end
          B_CODE_LO: begin
            if (!hex[4]) begin
              body_nxt = B_STOP;
            end else begin
              ent.has_item = 1'b1;
              ent.byte_val = {nib_r, hex[3:0]};
              body_nxt     = B_AFTER;
            end
          end
          B_VALUES: begin
            if (nib_v_r) begin
              nib_v_nxt = 1'b0;
              if (hex[4]) begin
                ent.has_item      = 1'b1;
                ent.item_is_value = 1'b1;
                ent.byte_val      = {nib_r, hex[3:0]};
              end else begin
                // lone digit dropped, character taken anew
                take_rest = 1'b1;
              end
            end else if (hex[4]) begin
              nib_nxt   = hex[3:0];
              nib_v_nxt = 1'b1;
            end else begin
              take_rest = 1'b1;
            end
            if (take_rest) begin
              if (is_close) begin
                body_nxt = B_CODE_HI;
              end else if (is_open) begin
                body_nxt = B_SKIP;
                skip_nxt = DEPTH_ONE;
              end
            end
          end
          B_SKIP: begin
            if (is_open) begin
              if (skip_r < DEPTH_MAX) skip_nxt = skip_r + DEPTH_ONE;
            end else if (is_close) begin
              skip_nxt = skip_r - DEPTH_ONE;
              if (skip_r == DEPTH_ONE) body_nxt = B_VALUES;
            end
          end
          default: ;
        endcase
      end

      if (eos) begin
        ent.has_done = 1'b1;
        ent.found    = (search_nxt == S_LIST) || (search_nxt == S_CLOSED);
        finished_nxt = 1'b1;
      end
    end
  end

  assign push_valid = accept && (ent.has_item || ent.has_done);
  assign push_entry = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_r   <= S_SEEK;
      body_r     <= B_CODE_HI;
      outer_r    <= '0;
      skip_r     <= '0;
      nib_r      <= '0;
      nib_v_r    <= 1'b0;
      finished_r <= 1'b0;
    end else if (accept) begin
      search_r   <= search_nxt;
      body_r     <= body_nxt;
      outer_r    <= outer_nxt;
      skip_r     <= skip_nxt;
      nib_r      <= nib_nxt;
      nib_v_r    <= nib_v_nxt;
      finished_r <= finished_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/vcp_queue.sv]
// short result queue between the decoder and the output stage
`default_nettype none

module vcp_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire vcp_pkg::vcp_entry_t  push_entry,
  input  wire logic                 pop,
  output vcp_pkg::vcp_entry_t       head,
  output vcp_pkg::vcp_qstat_t       stat
);

  localparam logic [vcp_pkg::QUEUE_CW-1:0] FULL_CNT = vcp_pkg::QUEUE_CW'(vcp_pkg::QUEUE_DEPTH);
  localparam logic [vcp_pkg::QUEUE_AW-1:0] LAST_IDX =
    vcp_pkg::QUEUE_AW'(vcp_pkg::QUEUE_DEPTH - 1);

  vcp_pkg::vcp_entry_t mem_r [vcp_pkg::QUEUE_DEPTH];
  logic [vcp_pkg::QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [vcp_pkg::QUEUE_CW-1:0] count_r;

  assign head       = mem_r[rd_ptr_r];
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == FULL_CNT);

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + 1'b1;
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/vcp_back.sv]
// back end: splits queue entries into result transfers behind an output register
`default_nettype none

module vcp_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire vcp_pkg::vcp_entry_t         head,
  input  wire vcp_pkg::vcp_qstat_t         stat,
  output logic                             pop,
  input  wire logic                        out_tready,
  output logic                             out_tvalid,
  output vcp_pkg::vcp_kind_t               out_kind,
  output logic [vcp_pkg::BYTE_W-1:0]       out_byte,
  output logic                             out_found,
  output logic                             out_last
);

  logic                        valid_r, valid_nxt;
  vcp_pkg::vcp_kind_t          kind_r, kind_nxt;
  logic [vcp_pkg::BYTE_W-1:0]  byte_r, byte_nxt;
  logic                        found_r, found_nxt;
  logic                        last_r, last_nxt;
  logic                        item_sent_r, item_sent_nxt;
  logic                        load;

  assign load = !valid_r || out_tready;

  always_comb begin
    valid_nxt     = valid_r;
    kind_nxt      = kind_r;
    byte_nxt      = byte_r;
    found_nxt     = found_r;
    last_nxt      = last_r;
    item_sent_nxt = item_sent_r;
    pop           = 1'b0;
    if (load) begin
      valid_nxt = 1'b0;
      if (!stat.empty) begin
        valid_nxt = 1'b1;
        if (head.has_item && !item_sent_r) begin
          kind_nxt  = head.item_is_value ? vcp_pkg::KIND_VALUE : vcp_pkg::KIND_CODE;
          byte_nxt  = head.byte_val;
          found_nxt = 1'b0;
          last_nxt  = !head.has_done;
          if (head.has_done) item_sent_nxt = 1'b1;
          else pop = 1'b1;
        end else begin
          kind_nxt      = vcp_pkg::KIND_DONE;
          byte_nxt      = '0;
          found_nxt     = head.found;
          last_nxt      = 1'b1;
          item_sent_nxt = 1'b0;
          pop           = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      item_sent_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      item_sent_r <= item_sent_nxt;
    end
    kind_r  <= kind_nxt;
    byte_r  <= byte_nxt;
    found_r <= found_nxt;
    last_r  <= last_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_kind   = kind_r;
  assign out_byte   = byte_r;
  assign out_found  = found_r;
  assign out_last   = last_r;

endmodule

`default_nettype wire

[sv/vcp_capability_list_parser.sv]
// top level of the vcp capability list parser
//
// usage:
// - input channel in_*: one utf-16 character of a monitor capabilities string per
//   transfer, in_tlast marks the final character; a zero character also ends the string
// - result channel out_*: feature codes (kind 0), their values (kind 1) and one done
//   result (kind 2) carrying list_found; out_tlast marks the last result of a character
// - throughput: one character per cycle while the queue has room; a character that yields
//   two results (a code or value plus done) occupies the output register once per result
// - path: the decoder writes a result into the four-entry queue, and the output register
//   loads it from the queue head
// - when the receiver stalls, the output register holds and the queue fills; in_tready
//   drops only when all four queue entries are taken
// - after the done result every further character is accepted and dropped until reset
// - reset (rst_n low, synchronous) restarts the keyword search, empties the queue and
//   clears the output valid; no clearing pass is needed
`default_nettype none
`include "vcp_capability_list_parser_macros.svh"

module vcp_capability_list_parser #(
  parameter int unsigned MAX_NEST_DEPTH = vcp_pkg::MAX_NEST_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] char_code
  input  wire logic        in_tlast,   // end_of_string
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [7:0] byte_value, [8] list_found, rest zero
  output logic [1:0]       out_tuser,  // [1:0] item_kind
  output logic             out_tlast   // last_of_run
);

  logic                       in_accept;
  logic                       q_push;
  logic                       q_pop;
  vcp_pkg::vcp_entry_t        q_wr_entry;
  vcp_pkg::vcp_entry_t        q_head;
  vcp_pkg::vcp_qstat_t        q_stat;
  vcp_pkg::vcp_kind_t         o_kind;
  logic [vcp_pkg::BYTE_W-1:0] o_byte;
  logic                       o_found;

  // input transfer completes only while the queue has room
  assign in_tready = !q_stat.full;
  assign in_accept = in_tvalid && in_tready;

  vcp_front #(
    .MAX_NEST_DEPTH(MAX_NEST_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .char_code    (in_tdata),
    .end_of_string(in_tlast),
    .push_valid   (q_push),
    .push_entry   (q_wr_entry)
  );

  vcp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_entry(q_wr_entry),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  vcp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .stat      (q_stat),
    .pop       (q_pop),
    .out_tready(out_tready),
    .out_tvalid(out_tvalid),
    .out_kind  (o_kind),
    .out_byte  (o_byte),
    .out_found (o_found),
    .out_last  (out_tlast)
  );

  // pack result fields, lowest bit first
  assign out_tdata = {7'd0, o_found, o_byte};
  assign out_tuser = o_kind;

  // checks

  // decoder never writes into a full queue
  `VCP_ASSERT_NOW(a_no_overflow, q_push, !q_stat.full, "push into full result queue")
  // output stage never pops an empty queue
  `VCP_ASSERT_NOW(a_no_underflow, q_pop, !q_stat.empty, "pop from empty result queue")
  // done is the final result of the string
  `VCP_ASSERT_NEXT(a_done_final,
    out_tvalid && out_tready && (out_tuser == vcp_pkg::KIND_DONE),
    !out_tvalid, "result after done")
  // a done result always closes its character's run
  `VCP_ASSERT_NOW(a_done_last, out_tvalid && (out_tuser == vcp_pkg::KIND_DONE),
    out_tlast, "done result without tlast")

endmodule

`default_nettype wire

[dv/vcp_capability_list_parser_test.sv]
// testbench for the vcp capability list parser: one long capabilities string, checked per result
module vcp_capability_list_parser_test;

  localparam int unsigned MAX_DEPTH   = vcp_pkg::MAX_NEST_DEPTH_DEF;
  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned LONG_HOLD   = 80;
  localparam int unsigned BODY_CHARS  = 1600;

  localparam logic [15:0] CH_NUL   = 16'h0000;
  localparam logic [15:0] CH_TAB   = 16'h0009;
  localparam logic [15:0] CH_SPACE = 16'h0020;
  localparam logic [15:0] CH_OPEN  = 16'h0028;
  localparam logic [15:0] CH_CLOSE = 16'h0029;

  // idle and stall percentages per phase of the run
  localparam int SEND_IDLE[4]  = '{0, 47, 0, 14};
  localparam int RECV_STALL[4] = '{0, 0, 47, 14};

  typedef enum logic [2:0] {
    SEEK_V, SEEK_C, SEEK_P, SEEK_OPEN, IN_LIST, LIST_CLOSED
  } search_state_e;

  typedef enum logic [2:0] {
    CODE_HI, CODE_LO, AFTER_CODE, IN_VALUES, SKIP_GROUP, STOPPED
  } body_state_e;

  typedef struct {
    vcp_pkg::vcp_kind_t kind;
    logic [7:0]         value;
    logic               found;
    logic               last;
  } parse_result_t;

  typedef struct {
    logic [15:0] code;
    logic        last;
  } string_char_t;

  // -1 for anything that is not a hex digit
  function automatic int hex_digit_value(logic [15:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  // tracks the parser state and holds the results still to come
  class capability_scoreboard;
    search_state_e search = SEEK_V;
    body_state_e   body = CODE_HI;
    logic [3:0]    held_nibble = '0;
    bit            held_valid = 0;
    logic [7:0]    list_depth = '0;
    logic [7:0]    skip_level = '0;
    bit            done_given = 0;
    parse_result_t awaited_results[$];
    int unsigned   faults = 0;

    function void flag(string msg);
      faults++;
      if (faults <= 10) $display("mismatch: %s", msg);
    endfunction

    function void push(vcp_pkg::vcp_kind_t kind, logic [7:0] value, logic found);
      awaited_results.insert(awaited_results.size(), '{kind, value, found, 1'b0});
    endfunction

    // one character inside the list, spaces and the closing paren already removed
    function void parse_body(logic [15:0] c);
      int d;
      d = hex_digit_value(c);
      if (body == AFTER_CODE) begin
        if (c == CH_OPEN) begin
          body = IN_VALUES;
          held_valid = 0;
          return;
        end
        body = CODE_HI;
      end
      case (body)
        CODE_HI: begin
          if (d < 0) body = STOPPED;
          else begin
            held_nibble = d[3:0];
            body = CODE_LO;
          end
        end
        CODE_LO: begin
          if (d < 0) body = STOPPED;
          else begin
            push(vcp_pkg::KIND_CODE, {held_nibble, d[3:0]}, 1'b0);
            body = AFTER_CODE;
          end
        end
        IN_VALUES: begin
          if (held_valid) begin
            held_valid = 0;
            if (d >= 0) begin
              push(vcp_pkg::KIND_VALUE, {held_nibble, d[3:0]}, 1'b0);
              return;
            end
          end else if (d >= 0) begin
            held_nibble = d[3:0];
            held_valid = 1;
            return;
          end
          // a lone digit is dropped and this character taken on its own
          if (c == CH_CLOSE) body = CODE_HI;
          else if (c == CH_OPEN) begin
            body = SKIP_GROUP;
            skip_level = 8'd1;
          end
        end
        SKIP_GROUP: begin
          if (c == CH_OPEN) begin
            if (skip_level < MAX_DEPTH) skip_level++;
          end else if (c == CH_CLOSE) begin
            skip_level--;
            if (skip_level == 0) body = IN_VALUES;
          end
        end
        default: begin
        end
      endcase
    endfunction

    // accepted input transfer: work out the results it causes
    function void note_char(logic [15:0] c, logic eos);
      int had;
      bit ends;
      had = awaited_results.size();
      ends = eos;
      if (done_given) return;
      if (c == CH_NUL) ends = 1;
      else begin
        case (search)
          SEEK_V, SEEK_C, SEEK_P, SEEK_OPEN: begin
            if (search == SEEK_C && (c == "c" || c == "C")) search = SEEK_P;
            else if (search == SEEK_P && (c == "p" || c == "P")) search = SEEK_OPEN;
            else if (search == SEEK_OPEN && (c == CH_SPACE || c == CH_TAB)) search = SEEK_OPEN;
            else if (search == SEEK_OPEN && c == CH_OPEN) begin
              search = IN_LIST;
              list_depth = 8'd1;
            end else if (c == "v" || c == "V") search = SEEK_C;
            else search = SEEK_V;
          end
          IN_LIST: begin
            if (c == CH_OPEN) begin
              if (list_depth < MAX_DEPTH) list_depth++;
              parse_body(c);
            end else if (c == CH_CLOSE) begin
              list_depth--;
              if (list_depth == 0) search = LIST_CLOSED;
              else parse_body(c);
            end else if (c != CH_SPACE) begin
              parse_body(c);
            end
          end
          default: begin
          end
        endcase
      end
      if (ends) begin
        push(vcp_pkg::KIND_DONE, 8'h00, search == IN_LIST || search == LIST_CLOSED);
        done_given = 1;
      end
      if (awaited_results.size() > had) awaited_results[awaited_results.size() - 1].last = 1'b1;
    endfunction

    // accepted result transfer: compare with the oldest expectation
    function void check_result(logic [1:0] kind, logic [15:0] data, logic last);
      parse_result_t want;
      if (awaited_results.size() == 0) begin
        flag($sformatf("result with nothing awaited: kind %0d data %h last %0b",
                       kind, data, last));
        return;
      end
      want = awaited_results.pop_front();
      if (kind !== want.kind || data[7:0] !== want.value || data[8] !== want.found ||
          data[15:9] !== 7'd0 || last !== want.last) begin
        flag($sformatf({"expected kind %0d value %02h found %0b last %0b, ",
                        "got kind %0d value %02h found %0b last %0b upper %02h"},
                       want.kind, want.value, want.found, want.last,
                       kind, data[7:0], data[8], last, data[15:9]));
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [15:0] char_code
  logic        in_tlast;   // end_of_string
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [7:0] byte_value, [8] list_found
  logic [1:0]  out_tuser;  // [1:0] item_kind
  logic        out_tlast;  // last_of_run

  capability_scoreboard parse_check;
  string_char_t         test_string[$];
  int                   directed_count;
  int                   idle_pct = 0;
  int                   stall_pct = 0;
  int                   hold_request = 0;
  int unsigned          quiet_cycles = 0;

  vcp_capability_list_parser u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- string building

  function automatic void add(logic [15:0] c, logic last = 1'b0);
    test_string.insert(test_string.size(), '{c, last});
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add({8'h00, s[i]});
  endfunction

  function automatic logic [15:0] hex_char(int unsigned nib);
    if (nib < 10) return 16'(16'h0030 + nib);
    return 16'(($urandom_range(1) ? 16'h0041 : 16'h0061) + nib - 10);
  endfunction

  function automatic void add_hex();
    add(hex_char($urandom_range(15)));
  endfunction

  // spaces are dropped anywhere inside the list
  function automatic void add_spaces();
    if ($urandom_range(3) == 0) repeat ($urandom_range(2, 1)) add(CH_SPACE);
  endfunction

  // anything but nul, space, parens and hex digits: tabs, ascii noise, wide characters
  function automatic logic [15:0] filler_char();
    logic [15:0] c;
    if ($urandom_range(9) == 0) return CH_TAB;
    do begin
      c = $urandom_range(1) ? 16'($urandom_range(127, 1)) : 16'($urandom_range(65535, 1));
    end while (hex_digit_value(c) >= 0 || c == CH_OPEN || c == CH_CLOSE || c == CH_SPACE);
    return c;
  endfunction

  // balanced sub-group, skipped by the parser
  function automatic void add_group(int levels);
    int count;
    count = $urandom_range(4);
    add(CH_OPEN);
    repeat (count) begin
      if (levels > 0 && $urandom_range(3) == 0) add_group(levels - 1);
      else if ($urandom_range(1)) add_hex();
      else add(filler_char());
    end
    add(CH_CLOSE);
  endfunction

  // one feature code, usually with a value list
  function automatic void add_feature();
    int pick;
    add_spaces();
    add_hex();
    add_spaces();
    add_hex();
    if ($urandom_range(9) < 6) begin
      add_spaces();
      add(CH_OPEN);
      repeat ($urandom_range(6)) begin
        pick = $urandom_range(19);
        if (pick < 12) begin
          add_hex();
          add_spaces();
          add_hex();
          add_spaces();
        end else if (pick < 14) add_hex();
        else if (pick < 17) add(filler_char());
        else add_group(2);
      end
      add(CH_CLOSE);
    end
  endfunction

  function automatic void build_string();
    // wide and tiny characters, a false start, keyword with space and tab before the paren
    add(16'hFFFF);
    add(16'h0001);
    add_text("vcx");
    add_text("VCP \t(");
    // codes 00 and ff, a value list with a split pair and a lone digit before the close
    add_text("00Ff(a 93)");
    directed_count = test_string.size();

    while (test_string.size() < directed_count + BODY_CHARS) add_feature();

    case ($urandom_range(3))
      0: add(CH_CLOSE);
      1: begin
        // non-hex where a code is due stops parsing; rest is consumed up to the close
        add(filler_char());
        add_group(2);
        add_hex();
        add(CH_CLOSE);
      end
      2: begin
        // nesting past the limit saturates both depths; the closes then end the list
        add_hex();
        add_hex();
        add(CH_OPEN);
        add(CH_OPEN);
        repeat (MAX_DEPTH + 5) add(CH_OPEN);
        repeat (MAX_DEPTH + 10) add(CH_CLOSE);
      end
      default: begin
        // list left open at the end of the string
      end
    endcase
    repeat ($urandom_range(3)) add(filler_char());
    if ($urandom_range(1)) add(CH_NUL, 1'($urandom_range(1)));
    else add(filler_char(), 1'b1);
    // ignored once done has been given
    repeat (4) add(16'($urandom), 1'($urandom_range(1)));
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_char(string_char_t ch);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch.code;
    in_tlast  <= ch.last;
    do @(posedge clk); while (!in_tready);
    parse_check.note_char(ch.code, ch.last);
  endtask

  // receiver: random stalls, plus one long hold-off counted here
  initial begin
    int hold_left;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // result transfers
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      parse_check.check_result(out_tuser, out_tdata, out_tlast);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int phase;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    rst_n     <= 1'b0;
    parse_check = new;
    build_string();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (test_string[i]) begin
      phase = i * 4 / test_string.size();
      idle_pct  = SEND_IDLE[phase];
      stall_pct = RECV_STALL[phase];
      // sender keeps offering while the receiver holds off, so the queue fills
      if (i == directed_count + 40) hold_request = LONG_HOLD;
      send_char(test_string[i]);
    end
    in_tvalid <= 1'b0;
    while (parse_check.awaited_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (parse_check.faults == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/vcp_pkg.sv
sv/vcp_front.sv
sv/vcp_queue.sv
sv/vcp_back.sv
sv/vcp_capability_list_parser.sv
dv/vcp_capability_list_parser_test.sv
